@@ rtl/core/morse_message_beacon_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the Morse message beacon.
// Every property is sampled on the block clock and is off during reset.
// ---------------------------------------------------------------------------
`ifndef MORSE_MESSAGE_BEACON_DEFINES_SVH
`define MORSE_MESSAGE_BEACON_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MMB_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define MMB_ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define MMB_ASSERT(lbl, prop, msg)
`define MMB_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

@@ rtl/core/mmb_pkg.sv @@
// ---------------------------------------------------------------------------
// mmb_pkg
// Constants, letter tables and shared types of the Morse message beacon.
// ---------------------------------------------------------------------------
`default_nettype none

package mmb_pkg;

   localparam int MSG_DEPTH = 64;
   localparam int MSG_AW    = $clog2(MSG_DEPTH);
   // Position must hold one past the last entry and the step beyond it.
   localparam int POS_W     = $clog2(MSG_DEPTH + 2);
   localparam int IDX_W     = 6;
   localparam int WIDE_W    = 13;

   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_STOP  = 2'd2;
   localparam logic [1:0] KIND_TICK  = 2'd3;

   localparam logic [7:0] CHAR_A          = 8'h41;
   localparam logic [7:0] CHAR_Z          = 8'h5A;
   localparam logic [4:0] NONLETTER_UNITS = 5'd4;
   localparam logic [4:0] UNITS_MAX       = 5'd16;

   localparam logic [15:0] UNIT_PATTERN [26] = '{
      16'h001D, 16'h0157, 16'h05D7, 16'h0057, 16'h0001, 16'h0175, 16'h0177,
      16'h0055, 16'h0005, 16'h1DDD, 16'h01D7, 16'h015D, 16'h0077, 16'h0017,
      16'h0777, 16'h05DD, 16'h1D77, 16'h005D, 16'h0015, 16'h0007, 16'h0075,
      16'h01D5, 16'h01DD, 16'h0757, 16'h1DD7, 16'h0577
   };

   localparam logic [4:0] UNIT_COUNT [26] = '{
      5'd8,  5'd12, 5'd14, 5'd10, 5'd4,  5'd12, 5'd12, 5'd10, 5'd6,
      5'd16, 5'd12, 5'd12, 5'd10, 5'd8,  5'd14, 5'd14, 5'd16, 5'd10,
      5'd8,  5'd6,  5'd10, 5'd12, 5'd12, 5'd14, 5'd16, 5'd14
   };

   typedef struct packed {
      logic              wr_en;
      logic [MSG_AW-1:0] wr_addr;
      logic [7:0]        wr_data;
      logic              rd_en;
      logic [MSG_AW-1:0] rd_addr;
   } mmb_store_req_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= CHAR_A) && (c <= CHAR_Z);
   endfunction

   function automatic logic [15:0] letter_pattern(input logic [7:0] c);
      logic [7:0] k;
      k = c - CHAR_A;
      if (is_letter(c)) begin
         return UNIT_PATTERN[k[4:0]];
      end
      return 16'h0000;
   endfunction

   function automatic logic [4:0] letter_units(input logic [7:0] c);
      logic [7:0] k;
      k = c - CHAR_A;
      if (is_letter(c)) begin
         return UNIT_COUNT[k[4:0]];
      end
      return NONLETTER_UNITS;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/morse_message_beacon.sv @@
// ---------------------------------------------------------------------------
// morse_message_beacon
// Tick-driven Morse lamp keyer playing a stored message.
// ---------------------------------------------------------------------------
// Requests arrive on req_* (valid/stall): kind selects a character write,
// start, stop or tick. Every request yields exactly one response on rsp_*
// carrying the lamp level and busy flag after that request.
// A request is registered on acceptance and the message memory is read in
// the same cycle; from the read stage it is then applied to the keyer state
// and loads the response register, once no response waits under rsp_stall.
// No new request is taken while one waits in the read stage: the memory
// read of a tick needs the read position left by the previous request.
// A response waiting under rsp_stall does not block the next acceptance;
// that request then waits in the read stage until the response is taken.
// Reset clears the keyer state, marks every message entry as zero and
// empties both stages.
// ---------------------------------------------------------------------------
`default_nettype none
`include "morse_message_beacon_defines.svh"

module morse_message_beacon
   import mmb_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [1:0]       req_kind,
   input  wire logic [IDX_W-1:0] req_char_index,
   input  wire logic [7:0]       req_char_value,
   input  wire logic             req_repeat_flag,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic                  rsp_lamp,
   output logic                  rsp_busy_res
);

   mmb_store_req_type store_req;
   logic [7:0]        rd_byte;
   logic [7:0]        fetch_byte;

   logic             req_fire;
   logic [WIDE_W-1:0] idx_wide;

   logic             s1_valid_ff, s1_valid_in;
   logic [1:0]       s1_kind_ff;
   logic             s1_repeat_ff;
   logic             s1_fire;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      pattern_ff, pattern_in;
   logic [4:0]       bits_left_ff, bits_left_in;
   logic             replay_ff, replay_in;
   logic             active_ff, active_in;
   logic             lamp_ff, lamp_in;
   logic [7:0]       first_byte_ff, first_byte_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_lamp_ff, rsp_busy_res_ff;

   logic [7:0]       cur_char;
   logic [15:0]      cur_pattern;
   logic [4:0]       cur_units;
   logic             shift_out;

   assign req_stall = s1_valid_ff;
   assign req_fire  = req_valid && !req_stall;
   assign s1_fire   = s1_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign idx_wide  = WIDE_W'(req_char_index);

   always_comb begin
      store_req.wr_en   = req_fire && (req_kind == KIND_WRITE) &&
                          (idx_wide < WIDE_W'(MSG_DEPTH));
      store_req.wr_addr = idx_wide[MSG_AW-1:0];
      store_req.wr_data = req_char_value;
      store_req.rd_en   = req_fire && (req_kind == KIND_TICK) &&
                          (pos_ff < POS_W'(MSG_DEPTH));
      store_req.rd_addr = pos_ff[MSG_AW-1:0];
   end

   mmb_msg_store u_store (
      .clock     (clock),
      .reset     (reset),
      .store_req (store_req),
      .rd_byte   (rd_byte)
   );

   // A position past the store reads as the end of the message. The position
   // does not move while a request waits in the read stage.
   assign fetch_byte = (pos_ff < POS_W'(MSG_DEPTH)) ? rd_byte : 8'h00;

   // The first character is shadowed so a wrap fetches it in the same step.
   always_comb begin
      first_byte_in = first_byte_ff;
      if (store_req.wr_en && (idx_wide == '0)) begin
         first_byte_in = req_char_value;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      pos_in       = pos_ff;
      pattern_in   = pattern_ff;
      bits_left_in = bits_left_ff;
      replay_in    = replay_ff;
      active_in    = active_ff;
      lamp_in      = lamp_ff;
      cur_char     = fetch_byte;
      cur_pattern  = pattern_ff;
      cur_units    = bits_left_ff;
      shift_out    = 1'b0;
      if (s1_fire) begin
         unique case (s1_kind_ff)
            KIND_WRITE: begin
            end
            KIND_START: begin
               pos_in    = '0;
               replay_in = s1_repeat_ff;
               active_in = 1'b1;
               lamp_in   = 1'b0;
            end
            KIND_STOP: begin
               active_in = 1'b0;
            end
            KIND_TICK: begin
               if (active_ff) begin
                  shift_out = 1'b1;
                  if (bits_left_ff == '0) begin
                     pos_in = pos_ff + POS_W'(1);
                     if (fetch_byte == 8'h00) begin
                        if (replay_ff) begin
                           cur_char = first_byte_ff;
                           pos_in   = POS_W'(1);
                        end else begin
                           active_in = 1'b0;
                           shift_out = 1'b0;
                        end
                     end
                     cur_pattern = letter_pattern(cur_char);
                     cur_units   = letter_units(cur_char);
                  end
                  if (shift_out) begin
                     lamp_in      = cur_pattern[0];
                     pattern_in   = cur_pattern >> 1;
                     bits_left_in = cur_units - 5'd1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pos_ff        <= '0;
         pattern_ff    <= '0;
         bits_left_ff  <= '0;
         replay_ff     <= 1'b0;
         active_ff     <= 1'b0;
         lamp_ff       <= 1'b0;
         first_byte_ff <= '0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         pos_ff        <= pos_in;
         pattern_ff    <= pattern_in;
         bits_left_ff  <= bits_left_in;
         replay_ff     <= replay_in;
         active_ff     <= active_in;
         lamp_ff       <= lamp_in;
         first_byte_ff <= first_byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_kind_ff   <= req_kind;
         s1_repeat_ff <= req_repeat_flag;
      end
      if (s1_fire) begin
         rsp_lamp_ff     <= lamp_in;
         rsp_busy_res_ff <= active_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_lamp     = rsp_lamp_ff;
   assign rsp_busy_res = rsp_busy_res_ff;

   `MMB_ASSERT_NEVER(a_rsp_no_overwrite, s1_fire && rsp_valid_ff && rsp_stall, "response overwritten")
   `MMB_ASSERT(a_units_range, bits_left_ff <= UNITS_MAX, "unit count out of range")
   `MMB_ASSERT(a_lamp_cause, !$stable(lamp_ff) |-> $past(s1_fire && (s1_kind_ff == KIND_TICK || s1_kind_ff == KIND_START)), "lamp changed without tick or start")
   `MMB_ASSERT(a_pos_range, active_ff |-> (pos_ff <= POS_W'(MSG_DEPTH)), "read position past message end")

endmodule

`default_nettype wire

@@ rtl/core/mmb_msg_store.sv @@
// ---------------------------------------------------------------------------
// mmb_msg_store
// Message character memory, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module mmb_msg_store
   import mmb_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mmb_store_req_type store_req,
   output logic [7:0]             rd_byte
);

   logic [7:0]           mem [MSG_DEPTH];
   logic [MSG_DEPTH-1:0] written_ff;
   logic [7:0]           rdata_ff;
   logic                 hit_ff;

   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         mem[store_req.wr_addr] <= store_req.wr_data;
      end
      if (store_req.rd_en) begin
         rdata_ff <= mem[store_req.rd_addr];
      end
   end

   // Entries never written since reset read as zero. The read result is
   // held until the next read, so a request waiting downstream keeps it.
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
         hit_ff     <= 1'b0;
      end else begin
         if (store_req.wr_en) begin
            written_ff[store_req.wr_addr] <= 1'b1;
         end
         if (store_req.rd_en) begin
            hit_ff <= written_ff[store_req.rd_addr];
         end
      end
   end

   assign rd_byte = hit_ff ? rdata_ff : 8'h00;

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the Morse message beacon: a directed table of
// requests, a full-store message, then random message episodes, each
// response checked in order against typed rows or a behavioral keyer copy.
// ---------------------------------------------------------------------------
`default_nettype none

module tb
   import mmb_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 640;
   localparam int DRAIN_CYCLES = 8;

   typedef struct {
      logic [1:0]       kind;
      logic [IDX_W-1:0] idx;
      logic [7:0]       val;
      logic             rep;
      bit               known;
      logic             lamp;
      logic             busy;
   } beacon_row_type;

   typedef struct {
      logic lamp;
      logic busy;
   } beacon_status_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [1:0]       req_kind = KIND_TICK;
   logic [IDX_W-1:0] req_char_index = '0;
   logic [7:0]       req_char_value = 8'h00;
   logic             req_repeat_flag = 1'b0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic             rsp_lamp;
   logic             rsp_busy_res;

   int                cycle_count = 0;
   int                mismatch_count = 0;
   logic              quiet_span;
   beacon_status_type beacon_status_q [$];

   // Keyer state mirrored by the bench.
   logic [7:0]       msg_mem [MSG_DEPTH];
   logic [6:0]       rd_pos = '0;
   logic [15:0]      unit_shift = '0;
   logic [4:0]       units_left = '0;
   logic             replay_on = 1'b0;
   logic             keying = 1'b0;
   logic             lamp_on = 1'b0;

   // Directed requests; rows marked known carry the response typed in.
   beacon_row_type plan [25] = '{
      '{KIND_TICK,  6'd0,  8'h00, 1'b0, 1, 1'b0, 1'b0},
      '{KIND_START, 6'd0,  8'h00, 1'b0, 1, 1'b0, 1'b1},
      '{KIND_TICK,  6'd0,  8'h00, 1'b0, 1, 1'b0, 1'b0},
      '{KIND_WRITE, 6'd0,  8'h45, 1'b0, 1, 1'b0, 1'b0},
      '{KIND_WRITE, 6'd1,  8'h5A, 1'b1, 1, 1'b0, 1'b0},
      '{KIND_WRITE, 6'd2,  8'h5B, 1'b0, 1, 1'b0, 1'b0},
      '{KIND_WRITE, 6'd63, 8'hFF, 1'b1, 1, 1'b0, 1'b0},
      '{KIND_START, 6'd63, 8'hFF, 1'b1, 1, 1'b0, 1'b1},
      '{KIND_TICK,  6'd0,  8'h00, 1'b0, 0, 1'b0, 1'b0},
      '{KIND_TICK,  6'd63, 8'hFF, 1'b1, 0, 1'b0, 1'b0},
      '{KIND_TICK,  6'd0,  8'h00, 1'b0, 0, 1'b0, 1'b0},
      '{KIND_TICK,  6'd0,  8'h00, 1'b0, 0, 1'b0, 1'b0},
      '{KIND_TICK,  6'd0,  8'h00, 1'b0, 0, 1'b0, 1'b0},
      '{KIND_START, 6'd0,  8'h00, 1'b0, 1, 1'b0, 1'b1},
      '{KIND_TICK,  6'd0,  8'h00, 1'b0, 0, 1'b0, 1'b0},
      '{KIND_TICK,  6'd0,  8'h00, 1'b0, 0, 1'b0, 1'b0},
      '{KIND_STOP,  6'd0,  8'h00, 1'b0, 0, 1'b0, 1'b0},
      '{KIND_TICK,  6'd0,  8'h00, 1'b0, 0, 1'b0, 1'b0},
      '{KIND_WRITE, 6'd0,  8'h00, 1'b0, 0, 1'b0, 1'b0},
      '{KIND_START, 6'd0,  8'h00, 1'b1, 1, 1'b0, 1'b1},
      '{KIND_TICK,  6'd0,  8'h00, 1'b0, 0, 1'b0, 1'b0},
      '{KIND_TICK,  6'd0,  8'h00, 1'b0, 0, 1'b0, 1'b0},
      '{KIND_TICK,  6'd0,  8'h00, 1'b0, 0, 1'b0, 1'b0},
      '{KIND_TICK,  6'd0,  8'h00, 1'b0, 0, 1'b0, 1'b0},
      '{KIND_STOP,  6'd0,  8'h00, 1'b0, 0, 1'b0, 1'b0}
   };

   morse_message_beacon uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_char_index  (req_char_index),
      .req_char_value  (req_char_value),
      .req_repeat_flag (req_repeat_flag),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_lamp        (rsp_lamp),
      .rsp_busy_res    (rsp_busy_res)
   );

   always #5 clock = ~clock;

   // Both sides run without idling through this window of cycles.
   assign quiet_span = (cycle_count >= 1000) && (cycle_count < 2000);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !quiet_span && ($urandom_range(0, 99) < 26);
   end

   // Applies one request to the mirrored keyer state.
   task automatic beacon_advance(input logic [1:0] kind, input logic [IDX_W-1:0] idx,
                                 input logic [7:0] val, input logic rep);
      logic [7:0] ch;
      logic [7:0] k;
      logic       shifting;
      case (kind)
         KIND_WRITE: begin
            if (idx < MSG_DEPTH) msg_mem[idx] = val;
         end
         KIND_START: begin
            rd_pos    = '0;
            replay_on = rep;
            keying    = 1'b1;
            lamp_on   = 1'b0;
         end
         KIND_STOP: begin
            keying = 1'b0;
         end
         default: begin
            if (keying) begin
               shifting = 1'b1;
               if (units_left == 5'd0) begin
                  ch     = (rd_pos < MSG_DEPTH) ? msg_mem[rd_pos[MSG_AW-1:0]] : 8'h00;
                  rd_pos = rd_pos + 7'd1;
                  if (ch == 8'h00) begin
                     // The end of the message either wraps at once or ends playback.
                     if (replay_on) begin
                        ch     = msg_mem[0];
                        rd_pos = 7'd1;
                     end else begin
                        keying   = 1'b0;
                        shifting = 1'b0;
                     end
                  end
                  if (shifting) begin
                     k = ch - CHAR_A;
                     if (ch >= CHAR_A && ch <= CHAR_Z) begin
                        unit_shift = UNIT_PATTERN[k[4:0]];
                        units_left = UNIT_COUNT[k[4:0]];
                     end else begin
                        unit_shift = 16'h0000;
                        units_left = NONLETTER_UNITS;
                     end
                  end
               end
               if (shifting) begin
                  lamp_on    = unit_shift[0];
                  unit_shift = unit_shift >> 1;
                  units_left = units_left - 5'd1;
               end
            end
         end
      endcase
   endtask

   // Drives one request, waits for it to be taken and queues its response.
   task automatic issue_req(input logic [1:0] kind, input logic [IDX_W-1:0] idx,
                            input logic [7:0] val, input logic rep,
                            input bit known, input logic lamp, input logic busy);
      beacon_status_type status;
      if (!quiet_span && $urandom_range(0, 99) < 26) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_char_index  <= idx;
      req_char_value  <= val;
      req_repeat_flag <= rep;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beacon_advance(kind, idx, val, rep);
      status.lamp = known ? lamp : lamp_on;
      status.busy = known ? busy : keying;
      beacon_status_q.push_back(status);
   endtask

   always @(posedge clock) begin
      beacon_status_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (beacon_status_q.size() == 0) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
               $display("unexpected response: lamp %0b busy %0b", rsp_lamp, rsp_busy_res);
         end else begin
            want = beacon_status_q.pop_front();
            if (rsp_lamp !== want.lamp || rsp_busy_res !== want.busy) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("response mismatch at cycle %0d: lamp %0b (want %0b), busy %0b (want %0b)",
                           cycle_count, rsp_lamp, want.lamp, rsp_busy_res, want.busy);
            end
         end
      end
   end

   initial begin
      int         random_sent;
      int         len;
      int         ticks;
      logic [7:0] v;
      foreach (msg_mem[i]) msg_mem[i] = 8'h00;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i])
         issue_req(plan[i].kind, plan[i].idx, plan[i].val, plan[i].rep,
                   plan[i].known, plan[i].lamp, plan[i].busy);

      // A message with no zero byte runs to the end of the store.
      for (int i = 0; i < MSG_DEPTH; i++) begin
         do v = 8'($urandom_range(1, 255)); while (v >= CHAR_A && v <= CHAR_Z);
         issue_req(KIND_WRITE, IDX_W'(i), v, 1'($urandom), 0, 1'b0, 1'b0);
      end
      issue_req(KIND_START, IDX_W'($urandom), 8'($urandom), 1'($urandom), 0, 1'b0, 1'b0);
      repeat (MSG_DEPTH * 4 + 8)
         issue_req(KIND_TICK, IDX_W'($urandom), 8'($urandom), 1'($urandom), 0, 1'b0, 1'b0);

      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
         for (int i = 0; i < len; i++) begin
            v = ($urandom_range(0, 4) != 0) ? CHAR_A + 8'($urandom_range(0, 25))
                                            : 8'($urandom_range(1, 255));
            issue_req(KIND_WRITE, IDX_W'(i), v, 1'($urandom), 0, 1'b0, 1'b0);
         end
         issue_req(KIND_WRITE, IDX_W'(len), 8'h00, 1'($urandom), 0, 1'b0, 1'b0);
         issue_req(KIND_START, IDX_W'($urandom), 8'($urandom), 1'($urandom), 0, 1'b0, 1'b0);
         ticks = $urandom_range(1, 60);
         for (int t = 0; t < ticks; t++) begin
            // Now and then a stray request of any kind lands mid-message.
            if ($urandom_range(0, 9) == 0)
               issue_req(2'($urandom), IDX_W'($urandom), 8'($urandom), 1'($urandom),
                         0, 1'b0, 1'b0);
            else
               issue_req(KIND_TICK, IDX_W'($urandom), 8'($urandom), 1'($urandom),
                         0, 1'b0, 1'b0);
         end
         random_sent += len + 2 + ticks;
         if ($urandom_range(0, 2) == 0) begin
            issue_req(KIND_STOP, IDX_W'($urandom), 8'($urandom), 1'($urandom), 0, 1'b0, 1'b0);
            random_sent++;
         end
      end
      req_valid <= 1'b0;

      while (beacon_status_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && beacon_status_q.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+rtl/core
rtl/core/mmb_pkg.sv
rtl/core/mmb_msg_store.sv
rtl/core/morse_message_beacon.sv
bench/tb.sv
